>>> src/ttsm_pkg.sv
// ----------------------------------------------------------------------------
// ttsm_pkg
// Shared constants, codes and types for the three-track sample mixer.
// ----------------------------------------------------------------------------
package ttsm_pkg;

    localparam int SAMPLE_DEPTH = 131072;
    localparam int NUM_TRACKS   = 3;
    localparam int POS_W        = $clog2(SAMPLE_DEPTH);
    localparam int CFG_W        = 17;
    localparam int CMP_W        = (POS_W > CFG_W) ? POS_W : CFG_W;
    localparam int SMP_W        = 24;
    localparam int MIX_W        = 26;
    localparam int TRK_W        = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int IN_DATA_W    = 48;
    localparam int IN_USER_W    = 4;
    localparam int OUT_DATA_W   = 56;

    typedef enum logic [1:0] {
        KIND_RECORD = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_TICK   = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRACK0_START = 3'd0,
        REG_TRACK0_END   = 3'd1,
        REG_TRACK1_START = 3'd2,
        REG_TRACK1_END   = 3'd3,
        REG_TRACK2_START = 3'd4,
        REG_TRACK2_END   = 3'd5
    } cfg_reg_t;

endpackage

>>> src/ttsm_ram.sv
// ----------------------------------------------------------------------------
// ttsm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ttsm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 131072
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/three_track_sample_mixer.sv
// a tick transfer passes the read stage, then the result register, to the output
// throughput: one item per cycle unless stalled; the three track memories are read in parallel
// the input stalls only while the result register is full and not taken
// reset clears play position, write counts, window registers and pipeline valids
// sample memories are not cleared; entries at or past a write count read as zero
// ----------------------------------------------------------------------------
// three_track_sample_mixer
// Records stereo pairs into three track memories and mixes them on playback.
// ----------------------------------------------------------------------------
module three_track_sample_mixer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [ttsm_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // left_in, right_in
    input  logic [ttsm_pkg::IN_USER_W-1:0]        s_axis_tuser,  // kind, track
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [ttsm_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // left_mix, right_mix, zero pad
    output logic                                  m_axis_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ttsm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ttsm_pkg::CFG_W-1:0]            cfg_data
);

    localparam int NT   = ttsm_pkg::NUM_TRACKS;
    localparam int PW   = ttsm_pkg::POS_W;
    localparam int CW   = ttsm_pkg::CMP_W;
    localparam int SW   = ttsm_pkg::SMP_W;
    localparam int MW   = ttsm_pkg::MIX_W;

    logic [ttsm_pkg::CFG_W-1:0] start_reg [NT];
    logic [ttsm_pkg::CFG_W-1:0] end_reg   [NT];
    logic [PW-1:0]              wp_reg    [NT];
    logic [PW-1:0]              play_position_reg;

    logic                       s1_valid_reg;
    logic [NT-1:0]              s1_hit_reg;
    logic                       s1_last_reg;

    logic                       m_valid_reg;
    logic signed [MW-1:0]       left_mix_reg;
    logic signed [MW-1:0]       right_mix_reg;
    logic                       last_reg;

    ttsm_pkg::kind_t            in_kind;
    logic [ttsm_pkg::TRK_W-1:0] in_track;
    logic                       in_xfer;
    logic                       tick_xfer;
    logic                       out_free;
    logic [PW-1:0]              pos_next;
    logic                       last_next;
    logic [CW-1:0]              pos_ext;
    logic [CW-1:0]              off      [NT];
    logic [NT-1:0]              hit;
    logic [NT-1:0]              ram_we;
    logic [2*SW-1:0]            ram_rdata [NT];
    logic signed [MW-1:0]       left_sum;
    logic signed [MW-1:0]       right_sum;

    assign in_kind   = ttsm_pkg::kind_t'(s_axis_tuser[1:0]);
    assign in_track  = s_axis_tuser[3:2];
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign tick_xfer = in_xfer && (in_kind == ttsm_pkg::KIND_TICK);
    assign cfg_ready = 1'b1;

    assign pos_next  = play_position_reg + PW'(1);
    assign last_next = (pos_next >= PW'(ttsm_pkg::SAMPLE_DEPTH - 2));
    assign pos_ext   = CW'(pos_next);

    always_comb
    begin
        for (int t = 0; t < NT; t++)
        begin
            off[t]    = pos_ext - CW'(start_reg[t]);
            hit[t]    = (pos_ext > CW'(start_reg[t])) && (pos_ext < CW'(end_reg[t]))
                        && (off[t] < CW'(wp_reg[t]));
            ram_we[t] = in_xfer && (in_kind == ttsm_pkg::KIND_RECORD)
                        && (in_track == ttsm_pkg::TRK_W'(t))
                        && (wp_reg[t] < PW'(ttsm_pkg::SAMPLE_DEPTH - 1));
        end
    end

    for (genvar g = 0; g < NT; g++)
    begin : g_track
        ttsm_ram #(
            .WIDTH (2 * SW),
            .DEPTH (ttsm_pkg::SAMPLE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[g]),
            .waddr (wp_reg[g]),
            .wdata (s_axis_tdata[2*SW-1:0]),
            .re    (tick_xfer),
            .raddr (off[g][PW-1:0]),
            .rdata (ram_rdata[g])
        );
    end

    always_comb
    begin
        left_sum  = '0;
        right_sum = '0;
        for (int t = 0; t < NT; t++)
        begin
            if (s1_hit_reg[t])
            begin
                left_sum  = left_sum  + MW'($signed(ram_rdata[t][SW-1:0]));
                right_sum = right_sum + MW'($signed(ram_rdata[t][2*SW-1:SW]));
            end
        end
    end

    // window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NT; t++)
            begin
                start_reg[t] <= '0;
                end_reg[t]   <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (ttsm_pkg::cfg_reg_t'(cfg_index))
                ttsm_pkg::REG_TRACK0_START: start_reg[0] <= cfg_data;
                ttsm_pkg::REG_TRACK0_END:   end_reg[0]   <= cfg_data;
                ttsm_pkg::REG_TRACK1_START: start_reg[1] <= cfg_data;
                ttsm_pkg::REG_TRACK1_END:   end_reg[1]   <= cfg_data;
                ttsm_pkg::REG_TRACK2_START: start_reg[2] <= cfg_data;
                ttsm_pkg::REG_TRACK2_END:   end_reg[2]   <= cfg_data;
                default: ;
            endcase
        end
    end

    // write counts and play position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NT; t++)
            begin
                wp_reg[t] <= '0;
            end
            play_position_reg <= '0;
        end
        else
        begin
            for (int t = 0; t < NT; t++)
            begin
                if (ram_we[t])
                begin
                    wp_reg[t] <= wp_reg[t] + PW'(1);
                end
                else if (in_xfer && (in_kind == ttsm_pkg::KIND_CLEAR)
                         && (in_track == ttsm_pkg::TRK_W'(t)))
                begin
                    wp_reg[t] <= '0;
                end
            end
            if (tick_xfer)
            begin
                play_position_reg <= last_next ? '0 : pos_next;
            end
        end
    end

    // read stage and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= tick_xfer;
            end
            if (out_free)
            begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            s1_hit_reg  <= hit;
            s1_last_reg <= last_next;
        end
        if (out_free && s1_valid_reg)
        begin
            left_mix_reg  <= left_sum;
            right_mix_reg <= right_sum;
            last_reg      <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(ttsm_pkg::OUT_DATA_W - 2 * MW)'(0), right_mix_reg, left_mix_reg};
    assign m_axis_tlast  = last_reg;

`ifndef SYNTHESIS
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && s1_valid_reg))
        else $error("input stalled without a blocked result");

    a_position_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        play_position_reg <= PW'(ttsm_pkg::SAMPLE_DEPTH - 3))
        else $error("play position beyond pass length");

    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_xfer && last_next) |=> (play_position_reg == '0))
        else $error("play position did not wrap after final tick");

    a_tick_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_xfer && out_free) |=> s1_valid_reg)
        else $error("accepted tick lost before read stage");
`endif

endmodule
